// ===== hw/rtl/tun_pkg.sv =====
// Shared types and constants for the triangle unit-normal block.
// Used by tun_front, tun_cell, triangle_unit_normal and the testbench; no dependencies.
`default_nettype none

package tun_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int UNIT_BITS         = 16;

    // valid and degenerate flag that travel with each transaction
    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/tun_front.sv =====
// Front pipeline: edge vectors, cross product, squared length.
// Depends on tun_pkg. Seven register stages, one transaction per cycle while i_en is high.
`default_nettype none

module tun_front #(
    parameter int COORD_BITS    = tun_pkg::COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic signed [COORD_BITS-1:0]          i_p0_x,
    input  wire logic signed [COORD_BITS-1:0]          i_p0_y,
    input  wire logic signed [COORD_BITS-1:0]          i_p0_z,
    input  wire logic signed [COORD_BITS-1:0]          i_p1_x,
    input  wire logic signed [COORD_BITS-1:0]          i_p1_y,
    input  wire logic signed [COORD_BITS-1:0]          i_p1_z,
    input  wire logic signed [COORD_BITS-1:0]          i_p2_x,
    input  wire logic signed [COORD_BITS-1:0]          i_p2_y,
    input  wire logic signed [COORD_BITS-1:0]          i_p2_z,
    output tun_pkg::t_ctl                              o_ctl,
    output logic [4*COORD_BITS+5:0]                    o_s,
    output logic [2:0][4*COORD_BITS+5+2*OUT_FRAC_BITS:0] o_d,
    output logic [2:0]                                 o_neg
);
    import tun_pkg::*;

    localparam int WE  = COORD_BITS + 1;
    localparam int WP  = 2 * WE;
    localparam int WC  = WP + 1;
    localparam int WM  = 2 * COORD_BITS + 2;
    localparam int L   = WM / 2;
    localparam int H   = WM - L;
    localparam int WSQ = 2 * WM;
    localparam int WS  = WSQ + 2;
    localparam int WD  = WS + 2 * OUT_FRAC_BITS;

    logic [6:0] r_v;
    logic       r_degen4, r_degen5, r_degen6, r_degen7;

    logic signed [WE-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [WP-1:0] r_m [6];
    logic signed [WC-1:0] r_c [3];
    logic [2:0][WM-1:0]   r_mag;
    logic [2:0]           r_neg4, r_neg5, r_neg6, r_neg7;
    logic [2*H-1:0]       r_hh [3];
    logic [H+L-1:0]       r_hl [3];
    logic [2*L-1:0]       r_ll [3];
    logic [WSQ-1:0]       r_sq [3];
    logic [WS-1:0]        r_s;
    logic [2:0][WD-1:0]   r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edges a = p0 - p1, b = p1 - p2
            r_ax <= WE'(i_p0_x) - WE'(i_p1_x);
            r_ay <= WE'(i_p0_y) - WE'(i_p1_y);
            r_az <= WE'(i_p0_z) - WE'(i_p1_z);
            r_bx <= WE'(i_p1_x) - WE'(i_p2_x);
            r_by <= WE'(i_p1_y) - WE'(i_p2_y);
            r_bz <= WE'(i_p1_z) - WE'(i_p2_z);

            r_m[0] <= r_ay * r_bz;
            r_m[1] <= r_az * r_by;
            r_m[2] <= r_az * r_bx;
            r_m[3] <= r_ax * r_bz;
            r_m[4] <= r_ax * r_by;
            r_m[5] <= r_ay * r_bx;

            for (int k = 0; k < 3; k++) begin
                r_c[k] <= WC'(r_m[2*k]) - WC'(r_m[2*k+1]);
            end

            r_degen4 <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
            for (int k = 0; k < 3; k++) begin
                r_neg4[k] <= r_c[k][WC-1];
                r_mag[k]  <= r_c[k][WC-1] ? WM'(-r_c[k]) : WM'(r_c[k]);
            end

            // square split into halves to keep each multiplier narrow
            r_degen5 <= r_degen4;
            r_neg5   <= r_neg4;
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= (2*H)'(r_mag[k][WM-1:L]) * (2*H)'(r_mag[k][WM-1:L]);
                r_hl[k] <= (H+L)'(r_mag[k][WM-1:L]) * (H+L)'(r_mag[k][L-1:0]);
                r_ll[k] <= (2*L)'(r_mag[k][L-1:0]) * (2*L)'(r_mag[k][L-1:0]);
            end

            r_degen6 <= r_degen5;
            r_neg6   <= r_neg5;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (WSQ'(r_hh[k]) << (2*L)) + (WSQ'(r_hl[k]) << (L+1))
                         + WSQ'(r_ll[k]);
            end

            r_degen7 <= r_degen6;
            r_neg7   <= r_neg6;
            r_s      <= WS'(r_sq[0]) + WS'(r_sq[1]) + WS'(r_sq[2]);
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= WD'(r_sq[k]) << (2*OUT_FRAC_BITS);
            end
        end
    end

    assign o_ctl.valid = r_v[6];
    assign o_ctl.degen = r_degen7;
    assign o_s         = r_s;
    assign o_d         = r_d;
    assign o_neg       = r_neg7;

endmodule

`default_nettype wire

// ===== hw/rtl/tun_cell.sv =====
// One cell of the root-and-divide chain: decides one quotient bit for three lanes.
// Depends on tun_pkg. Keeps remainder D = c^2*4^F - q^2*s and Y = q*s per lane.
`default_nettype none

module tun_cell #(
    parameter int WS   = 70,
    parameter int FRAC = tun_pkg::OUT_FRAC_BITS_DEF,
    parameter int BIT  = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire tun_pkg::t_ctl                i_ctl,
    input  wire logic [WS-1:0]                i_s,
    input  wire logic [2:0][WS+2*FRAC-1:0]    i_d,
    input  wire logic [2:0][WS+FRAC:0]        i_y,
    input  wire logic [2:0][FRAC:0]           i_q,
    input  wire logic [2:0]                   i_neg,
    output tun_pkg::t_ctl                     o_ctl,
    output logic [WS-1:0]                     o_s,
    output logic [2:0][WS+2*FRAC-1:0]         o_d,
    output logic [2:0][WS+FRAC:0]             o_y,
    output logic [2:0][FRAC:0]                o_q,
    output logic [2:0]                        o_neg
);
    import tun_pkg::*;

    localparam int WD = WS + 2 * FRAC;
    localparam int WY = WS + FRAC + 1;
    localparam int WT = WD + 2;
    localparam int WQ = FRAC + 1;

    logic [WT-1:0]      trial [3];
    logic [2:0]         take;
    logic [2:0][WD-1:0] n_d;
    logic [2:0][WY-1:0] n_y;
    logic [2:0][WQ-1:0] n_q;

    logic               r_valid;
    logic               r_degen;
    logic [WS-1:0]      r_s;
    logic [2:0][WD-1:0] r_d;
    logic [2:0][WY-1:0] r_y;
    logic [2:0][WQ-1:0] r_q;
    logic [2:0]         r_neg;

    // (q + 2^b)^2 s = q^2 s + 2^(b+1) q s + 4^b s
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            trial[k] = (WT'(i_y[k]) << (BIT + 1)) + (WT'(i_s) << (2 * BIT));
            take[k]  = trial[k] <= WT'(i_d[k]);
            n_d[k]   = take[k] ? i_d[k] - WD'(trial[k]) : i_d[k];
            n_y[k]   = take[k] ? i_y[k] + (WY'(i_s) << BIT) : i_y[k];
            n_q[k]   = take[k] ? i_q[k] | (WQ'(1) << BIT) : i_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_degen <= i_ctl.degen;
            r_s     <= i_s;
            r_d     <= n_d;
            r_y     <= n_y;
            r_q     <= n_q;
            r_neg   <= i_neg;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.degen = r_degen;
    assign o_s         = r_s;
    assign o_d         = r_d;
    assign o_y         = r_y;
    assign o_q         = r_q;
    assign o_neg       = r_neg;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_unit_normal.sv =====
// Unit face normal of a triangle given as three signed fixed-point vertices.
// Depends on tun_pkg, tun_front and tun_cell.
//
// Input channel: i_in_valid / o_in_ready with nine vertex coordinates.
// Output channel: o_out_valid / i_out_ready with the normal in signed
// Q1.14 (at the default OUT_FRAC_BITS) and a degenerate flag that is set,
// with a zero vector, when the cross product has zero length.
// A result passes through seven front stages, one chain cell per quotient
// bit, and the output register.
// Throughput is one transaction per cycle unless the receiver stalls; each
// cell decides one bit of all three components by one shift-add compare,
// so the chain of OUT_FRAC_BITS + 1 cells sets the latency, not the rate.
// The output register holds a result while the receiver stalls; input is
// still taken as long as the output register is empty or being drained,
// otherwise the whole pipeline holds in place.
// Reset clears all valid bits, so it creates no result; results in flight are dropped.
`default_nettype none

module triangle_unit_normal #(
    parameter int COORD_BITS    = tun_pkg::COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [COORD_BITS-1:0]        i_p0_x,
    input  wire logic signed [COORD_BITS-1:0]        i_p0_y,
    input  wire logic signed [COORD_BITS-1:0]        i_p0_z,
    input  wire logic signed [COORD_BITS-1:0]        i_p1_x,
    input  wire logic signed [COORD_BITS-1:0]        i_p1_y,
    input  wire logic signed [COORD_BITS-1:0]        i_p1_z,
    input  wire logic signed [COORD_BITS-1:0]        i_p2_x,
    input  wire logic signed [COORD_BITS-1:0]        i_p2_y,
    input  wire logic signed [COORD_BITS-1:0]        i_p2_z,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [tun_pkg::UNIT_BITS-1:0]     o_unit_x,
    output logic signed [tun_pkg::UNIT_BITS-1:0]     o_unit_y,
    output logic signed [tun_pkg::UNIT_BITS-1:0]     o_unit_z,
    output logic                                     o_degenerate
);
    import tun_pkg::*;

    localparam int WS   = 4 * COORD_BITS + 6;
    localparam int WD   = WS + 2 * OUT_FRAC_BITS;
    localparam int WY   = WS + OUT_FRAC_BITS + 1;
    localparam int WQ   = OUT_FRAC_BITS + 1;
    localparam int NC   = OUT_FRAC_BITS + 1;
    localparam int WX   = (WQ + 1 > UNIT_BITS) ? WQ + 1 : UNIT_BITS;

    logic               en;
    t_ctl               ctl_c [NC+1];
    logic [WS-1:0]      s_c   [NC+1];
    logic [2:0][WD-1:0] d_c   [NC+1];
    logic [2:0][WY-1:0] y_c   [NC+1];
    logic [2:0][WQ-1:0] q_c   [NC+1];
    logic [2:0]         neg_c [NC+1];

    logic [WX-1:0]      val [3];

    logic               r_out_valid;
    logic [UNIT_BITS-1:0] r_unit [3];
    logic               r_degen;

    // advance the whole pipeline whenever the output register can take a result
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    tun_front #(
        .COORD_BITS    (COORD_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_p0_x  (i_p0_x),
        .i_p0_y  (i_p0_y),
        .i_p0_z  (i_p0_z),
        .i_p1_x  (i_p1_x),
        .i_p1_y  (i_p1_y),
        .i_p1_z  (i_p1_z),
        .i_p2_x  (i_p2_x),
        .i_p2_y  (i_p2_y),
        .i_p2_z  (i_p2_z),
        .o_ctl   (ctl_c[0]),
        .o_s     (s_c[0]),
        .o_d     (d_c[0]),
        .o_neg   (neg_c[0])
    );

    assign y_c[0] = '0;
    assign q_c[0] = '0;

    // cell k decides quotient bit OUT_FRAC_BITS - k
    for (genvar k = 0; k < NC; k++) begin : g_cell
        tun_cell #(
            .WS   (WS),
            .FRAC (OUT_FRAC_BITS),
            .BIT  (OUT_FRAC_BITS - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_c[k]),
            .i_s     (s_c[k]),
            .i_d     (d_c[k]),
            .i_y     (y_c[k]),
            .i_q     (q_c[k]),
            .i_neg   (neg_c[k]),
            .o_ctl   (ctl_c[k+1]),
            .o_s     (s_c[k+1]),
            .o_d     (d_c[k+1]),
            .o_y     (y_c[k+1]),
            .o_q     (q_c[k+1]),
            .o_neg   (neg_c[k+1])
        );
    end

    // apply sign, drop the result of a zero-length normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            val[k] = neg_c[NC][k] ? WX'(-WX'(q_c[NC][k])) : WX'(q_c[NC][k]);
            if (ctl_c[NC].degen) begin
                val[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= ctl_c[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_unit[k] <= val[k][UNIT_BITS-1:0];
            end
            r_degen <= ctl_c[NC].degen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_unit_x     = r_unit[0];
    assign o_unit_y     = r_unit[1];
    assign o_unit_z     = r_unit[2];
    assign o_degenerate = r_degen;

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0))
        else $error("degenerate result carries a nonzero component");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("pipeline held without a stalled result");

    a_last_cell_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && ctl_c[NC].valid |=> o_out_valid)
        else $error("result from the chain did not reach the output");

endmodule

`default_nettype wire

// ===== verif/tb_triangle_unit_normal.sv =====
// Testbench for triangle_unit_normal: streams triangles and checks each unit normal
// against an exact integer predictor of the normalized cross product.
// Depends on tun_pkg and the triangle_unit_normal RTL.
`timescale 1ns / 100ps

module tb_triangle_unit_normal;

    localparam int CB        = tun_pkg::COORD_BITS_DEF;
    localparam int FB        = tun_pkg::OUT_FRAC_BITS_DEF;
    localparam int UB        = tun_pkg::UNIT_BITS;
    localparam int MAX_CYC   = 600000;
    localparam int TAIL_CYC  = FB + 20;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        coord_t v[9];   // p0 xyz, p1 xyz, p2 xyz
    } tri_t;

    typedef struct {
        logic [UB-1:0] ux;
        logic [UB-1:0] uy;
        logic [UB-1:0] uz;
        logic          degen;
    } normal_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    coord_t pin[9];
    logic o_in_ready, o_out_valid, o_degenerate;
    logic signed [UB-1:0] o_unit_x, o_unit_y, o_unit_z;

    normal_t normal_q[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int n_checked = 0;
    int n_degen = 0;
    int cycles = 0;

    initial begin
        for (int i = 0; i < 9; i++) pin[i] = '0;
    end

    always #10 i_clk = ~i_clk;

    triangle_unit_normal dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_p0_x       (pin[0]),
        .i_p0_y       (pin[1]),
        .i_p0_z       (pin[2]),
        .i_p1_x       (pin[3]),
        .i_p1_y       (pin[4]),
        .i_p1_z       (pin[5]),
        .i_p2_x       (pin[6]),
        .i_p2_y       (pin[7]),
        .i_p2_z       (pin[8]),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_unit_x     (o_unit_x),
        .o_unit_y     (o_unit_y),
        .o_unit_z     (o_unit_z),
        .o_degenerate (o_degenerate)
    );

    // exact trunc(c * 2^FB / |c|) per component, by bitwise search on squares
    function automatic normal_t unit_normal(tri_t t);
        longint a[3], b[3], c[3];
        logic [127:0] m[3];
        logic [127:0] s, tgt, q, cand;
        normal_t r;
        logic [UB-1:0] u[3];
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'(t.v[k]) - longint'(t.v[k+3]);
            b[k] = longint'(t.v[k+3]) - longint'(t.v[k+6]);
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        s = '0;
        for (int k = 0; k < 3; k++) begin
            m[k] = (c[k] < 0) ? 128'(-c[k]) : 128'(c[k]);
            s = s + m[k] * m[k];
        end
        if (s == 0) begin
            r.ux = '0; r.uy = '0; r.uz = '0; r.degen = 1'b1;
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            tgt = (m[k] * m[k]) << (2 * FB);
            q = '0;
            for (int bt = FB; bt >= 0; bt--) begin
                cand = q | (128'd1 << bt);
                if (cand * cand * s <= tgt) q = cand;
            end
            if (c[k] < 0) q = -q;
            u[k] = q[UB-1:0];
        end
        r.ux = u[0]; r.uy = u[1]; r.uz = u[2]; r.degen = 1'b0;
        return r;
    endfunction

    // drive one triangle and hold it until the input handshake accepts it
    task automatic send_tri(tri_t t);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++) pin[i] = t.v[i];
        i_in_valid = 1'b1;
        normal_q.push_back(unit_normal(t));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    function automatic tri_t rand_tri(int span);
        tri_t t;
        for (int i = 0; i < 9; i++) begin
            if (span >= 32768) t.v[i] = coord_t'($urandom);
            else t.v[i] = coord_t'($urandom_range(2 * span) - span);
        end
        return t;
    endfunction

    function automatic tri_t mk(int x0, int y0, int z0, int x1, int y1, int z1,
                                int x2, int y2, int z2);
        tri_t t;
        t.v[0] = coord_t'(x0); t.v[1] = coord_t'(y0); t.v[2] = coord_t'(z0);
        t.v[3] = coord_t'(x1); t.v[4] = coord_t'(y1); t.v[5] = coord_t'(z1);
        t.v[6] = coord_t'(x2); t.v[7] = coord_t'(y2); t.v[8] = coord_t'(z2);
        return t;
    endfunction

    task automatic test_directed();
        send_tri(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(mk(5, -7, 9, 5, -7, 9, 5, -7, 9));
        send_tri(mk(0, 0, 0, 256, 256, 256, 512, 512, 512));
        send_tri(mk(256, 0, 0, 0, 0, 0, 0, 256, 0));
        send_tri(mk(0, 256, 0, 0, 0, 0, 0, 0, 256));
        send_tri(mk(0, 0, 256, 0, 0, 0, 256, 0, 0));
        send_tri(mk(0, 256, 0, 0, 0, 0, 256, 0, 0));
        send_tri(mk(32767, 32767, 32767, -32768, -32768, -32768,
                    32767, -32768, 32767));
        send_tri(mk(32767, -32768, 0, -32768, 32767, 0, 32767, 32767, -32768));
        send_tri(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                    -32768, 32767, 32767));
        send_tri(mk(32767, 0, 0, -32768, 0, 0, 0, 32767, 0));
        send_tri(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send_tri(mk(1, 1, 0, 0, 0, 0, 1, 0, 1));
        send_tri(mk(-1, -1, -1, 0, 0, 0, 1, 2, 3));
        send_tri(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                    -32768, 32767, -32768));
        send_tri(mk(100, 200, 300, 100, 200, 300, -5, 7, 11));
        send_tri(mk(3, 4, 0, 0, 0, 0, -4, 3, 0));
        send_tri(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_tri(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        wait_drained();
    endtask

    // mostly full-range, some small, some coincident or collinear
    task automatic test_random(int n);
        tri_t t;
        int sel, k;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 55) t = rand_tri(32768);
            else if (sel < 85) t = rand_tri(8);
            else begin
                t = rand_tri(4000);
                k = $urandom_range(2);
                for (int j = 0; j < 3; j++) begin
                    if (k == 0) t.v[6+j] = t.v[3+j];
                    else if (k == 1) t.v[j] = t.v[3+j];
                    else t.v[6+j] = coord_t'(2 * t.v[3+j] - t.v[j]);
                end
            end
            send_tri(t);
        end
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        normal_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normal_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = normal_q.pop_front();
                n_checked++;
                if (e.degen) n_degen++;
                if (o_unit_x !== e.ux || o_unit_y !== e.uy || o_unit_z !== e.uz ||
                    o_degenerate !== e.degen) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d %0d %0d d%0b got %0d %0d %0d d%0b",
                                 $signed(e.ux), $signed(e.uy), $signed(e.uz), e.degen,
                                 o_unit_x, o_unit_y, o_unit_z, o_degenerate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(300);
        send_idle_pct = 59; recv_stall_pct = 0;  test_random(250);
        send_idle_pct = 0;  recv_stall_pct = 59; test_random(250);
        send_idle_pct = 25; recv_stall_pct = 25; test_random(150);
        // no idling and no stalls, then a full drain
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(130);
        $display("covered %0d triangles (%0d degenerate) over four idle/stall mixes",
                 n_checked, n_degen);
        if (errors == 0 && normal_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("errors: %0d, pending: %0d", errors, normal_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tun_pkg.sv
hw/rtl/tun_front.sv
hw/rtl/tun_cell.sv
hw/rtl/triangle_unit_normal.sv
verif/tb_triangle_unit_normal.sv
